### src/macd_pkg.sv
// Shared constants, types and helper functions of the MACD indicator stream.
package macd_pkg;

   localparam int CFG_W      = 11;   // length registers and sample counter
   localparam int PRICE_W    = 32;   // Q16.16 sample and result fields
   localparam int AVG_W      = 48;   // Q16.32 averages
   localparam int SUM_W      = 48;   // Q32.16 seed sums
   localparam int SUM_MAG_W  = 42;   // magnitude of a seed sum over a full period
   localparam int FRAC_SHIFT = 16;   // Q16.16 to Q16.32
   localparam int NUM_W      = SUM_MAG_W + FRAC_SHIFT;
   localparam int QUO_W      = 48;
   localparam int DIFF_W     = AVG_W + 1;
   localparam int ALPHA_W    = 32;
   localparam int PROD_W     = 64;
   localparam int DIV_CNT_W  = $clog2(QUO_W);
   localparam int NUM_AVG    = 3;
   localparam int IDX_W      = $clog2(NUM_AVG);
   localparam int CSR_IDX_W  = 2;

   localparam logic [CFG_W-1:0] MAX_PERIOD = CFG_W'(1024);

   // Numerator of the smoothing factor: 2^33
   localparam logic [QUO_W-1:0] ALPHA_NUM = QUO_W'(1) << 33;

   typedef logic [IDX_W-1:0] avg_idx_type;
   localparam avg_idx_type AVG_FAST   = IDX_W'(0);
   localparam avg_idx_type AVG_SLOW   = IDX_W'(1);
   localparam avg_idx_type AVG_SIGNAL = IDX_W'(2);

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_FAST_LENGTH   = CSR_IDX_W'(0);
   localparam csr_index_type REG_SLOW_LENGTH   = CSR_IDX_W'(1);
   localparam csr_index_type REG_SIGNAL_LENGTH = CSR_IDX_W'(2);

   localparam logic [CFG_W-1:0] FAST_LENGTH_RESET   = CFG_W'(12);
   localparam logic [CFG_W-1:0] SLOW_LENGTH_RESET   = CFG_W'(26);
   localparam logic [CFG_W-1:0] SIGNAL_LENGTH_RESET = CFG_W'(9);

   // Clamp a raw length into 1 .. MAX_PERIOD
   function automatic logic [CFG_W-1:0] eff_period(input logic [CFG_W-1:0] raw);
      logic [CFG_W-1:0] p;
      if (raw == '0) begin
         p = CFG_W'(1);
      end else if (raw > MAX_PERIOD) begin
         p = MAX_PERIOD;
      end else begin
         p = raw;
      end
      return p;
   endfunction

   // Saturate a 33-bit signed value to 32 bits
   function automatic logic [PRICE_W-1:0] sat32(input logic [PRICE_W:0] v);
      logic [PRICE_W-1:0] r;
      if (v[PRICE_W] != v[PRICE_W-1]) begin
         r = v[PRICE_W] ? {1'b1, {(PRICE_W-1){1'b0}}} : {1'b0, {(PRICE_W-1){1'b1}}};
      end else begin
         r = v[PRICE_W-1:0];
      end
      return r;
   endfunction

endpackage

### src/macd_indicator_stream.sv
// MACD indicator stream: three averages computed in turn on one shared divider and multiplier.
// A result is written once every average has been stepped; req_ready rises again together with
// rsp_valid. An average in its lead-in skips the difference, multiply and update states; a seeding
// step adds a pass of the serial divider (48 quotient bits), as does an uncached smoothing factor
// (after reset or a changed period). A stalled output register holds the block in its last state.
// Synchronous reset restores the default lengths and clears the count, averages and seed sums.
module macd_indicator_stream (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [macd_pkg::PRICE_W-1:0] req_price,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [macd_pkg::PRICE_W-1:0] rsp_macd_value,
   output logic signed [macd_pkg::PRICE_W-1:0] rsp_signal_value,
   output logic signed [macd_pkg::PRICE_W-1:0] rsp_histogram_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  macd_pkg::csr_index_type          csr_index,
   input  logic [macd_pkg::CFG_W-1:0]       csr_data
);
   import macd_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_SELECT  = 11'b000_0000_0010,
      S_DIV     = 11'b000_0000_0100,
      S_DIV_END = 11'b000_0000_1000,
      S_DIFF    = 11'b000_0001_0000,
      S_MUL_LO  = 11'b000_0010_0000,
      S_MUL_HI  = 11'b000_0100_0000,
      S_UPDATE  = 11'b000_1000_0000,
      S_APPLY   = 11'b001_0000_0000,
      S_NEXT    = 11'b010_0000_0000,
      S_FINISH  = 11'b100_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   avg_idx_type             k_ff, k_in;
   logic [CFG_W-1:0]        cnt_ff, cnt_in;
   logic [CFG_W-1:0]        len_ff [NUM_AVG];
   logic [CFG_W-1:0]        len_in [NUM_AVG];
   logic [PRICE_W-1:0]      price_ff, price_in;
   logic [PRICE_W-1:0]      macd_ff, macd_in;
   logic [AVG_W-1:0]        avg_ff [NUM_AVG];
   logic [AVG_W-1:0]        avg_in [NUM_AVG];
   logic [SUM_W-1:0]        sum_ff [NUM_AVG];
   logic [SUM_W-1:0]        sum_in [NUM_AVG];
   logic [AVG_W-1:0]        res_ff [NUM_AVG];
   logic [AVG_W-1:0]        res_in [NUM_AVG];
   logic [ALPHA_W-1:0]      alpha_ff [NUM_AVG];
   logic [ALPHA_W-1:0]      alpha_in [NUM_AVG];
   logic [CFG_W-1:0]        tag_ff [NUM_AVG];
   logic [CFG_W-1:0]        tag_in [NUM_AVG];
   logic [NUM_AVG-1:0]      alpha_ok_ff, alpha_ok_in;
   logic [CFG_W-1:0]        den_ff, den_in;
   logic [CFG_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                    seed_mode_ff, seed_mode_in;
   logic                    neg_ff, neg_in;
   logic [DIFF_W-1:0]       mag_ff, mag_in;
   logic [PROD_W-1:0]       lp_ff, lp_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DIFF_W-1:0]       q_ff, q_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0]      rsp_macd_ff, rsp_macd_in;
   logic [PRICE_W-1:0]      rsp_signal_ff, rsp_signal_in;
   logic [PRICE_W-1:0]      rsp_hist_ff, rsp_hist_in;

   logic [CFG_W-1:0]        p_cur;
   logic [PRICE_W-1:0]      x_cur;
   logic [ALPHA_W-1:0]      alpha_cur;
   logic                    alpha_hit;
   logic [ALPHA_W-1:0]      mul_a;
   logic [PROD_W-1:0]       mul_p;

   assign p_cur     = eff_period(len_ff[k_ff]);
   assign x_cur     = (k_ff == AVG_SIGNAL) ? macd_ff : price_ff;
   assign alpha_cur = alpha_ff[k_ff];
   assign alpha_hit = alpha_ok_ff[k_ff] && (tag_ff[k_ff] == p_cur);

   // The one multiplier: low word of the magnitude first, then its high part
   assign mul_a = (state_ff == S_MUL_HI) ? ALPHA_W'(mag_ff[DIFF_W-1:ALPHA_W])
                                         : mag_ff[ALPHA_W-1:0];
   assign mul_p = PROD_W'(mul_a) * PROD_W'(alpha_cur);

   assign req_ready           = (state_ff == S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_macd_value      = rsp_macd_ff;
   assign rsp_signal_value    = rsp_signal_ff;
   assign rsp_histogram_value = rsp_hist_ff;

   always_comb begin
      logic [CFG_W:0]         ip1;
      logic [SUM_W-1:0]       s_new;
      logic [SUM_W-1:0]       s_mag;
      logic [NUM_W-1:0]       num;
      logic [AVG_W-1:0]       xs;
      logic [DIFF_W-1:0]      d;
      logic [CFG_W:0]         trial;
      logic                   qbit;
      logic [AVG_W-1:0]       seed_val;
      logic [DIFF_W-1:0]      delta;
      logic [DIFF_W-1:0]      fs_diff;
      logic [PRICE_W-1:0]     macd_c;
      logic [PRICE_W-1:0]     sig_c;

      state_in      = state_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      len_in        = len_ff;
      price_in      = price_ff;
      macd_in       = macd_ff;
      avg_in        = avg_ff;
      sum_in        = sum_ff;
      res_in        = res_ff;
      alpha_in      = alpha_ff;
      tag_in        = tag_ff;
      alpha_ok_in   = alpha_ok_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      seed_mode_in  = seed_mode_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      lp_in         = lp_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_macd_in   = rsp_macd_ff;
      rsp_signal_in = rsp_signal_ff;
      rsp_hist_in   = rsp_hist_ff;

      ip1      = {1'b0, cnt_ff} + (CFG_W+1)'(1);
      s_new    = sum_ff[k_ff] + SUM_W'(signed'(x_cur));
      s_mag    = s_new[SUM_W-1] ? (~s_new + SUM_W'(1)) : s_new;
      num      = {s_mag[SUM_MAG_W-1:0], {FRAC_SHIFT{1'b0}}}
                 + (s_new[SUM_W-1] ? NUM_W'(p_cur - CFG_W'(1)) : NUM_W'(0));
      xs       = {x_cur, {FRAC_SHIFT{1'b0}}};
      d        = {xs[AVG_W-1], xs} - {avg_ff[k_ff][AVG_W-1], avg_ff[k_ff]};
      trial    = {rem_ff, quo_ff[QUO_W-1]};
      qbit     = (trial >= {1'b0, den_ff});
      seed_val = neg_ff ? (~quo_ff + AVG_W'(1)) : quo_ff;
      delta    = neg_ff ? (~q_ff + DIFF_W'(1)) : q_ff;
      fs_diff  = {res_ff[AVG_FAST][AVG_W-1], res_ff[AVG_FAST]}
                 - {res_ff[AVG_SLOW][AVG_W-1], res_ff[AVG_SLOW]};
      macd_c   = sat32(fs_diff[DIFF_W-1:FRAC_SHIFT]);
      sig_c    = res_ff[AVG_SIGNAL][AVG_W-1:FRAC_SHIFT];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FAST_LENGTH:   len_in[AVG_FAST]   = csr_data;
            REG_SLOW_LENGTH:   len_in[AVG_SLOW]   = csr_data;
            REG_SIGNAL_LENGTH: len_in[AVG_SIGNAL] = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               price_in = req_price;
               k_in     = AVG_FAST;
               state_in = S_SELECT;
            end
         end
         S_SELECT: begin
            if (ip1 < {1'b0, p_cur}) begin
               // still in the lead-in: accumulate, output zero
               sum_in[k_ff] = s_new;
               res_in[k_ff] = '0;
               state_in     = S_NEXT;
            end else if (ip1 == {1'b0, p_cur}) begin
               // seed with the mean; negative sums divide rounding downwards
               sum_in[k_ff] = s_new;
               neg_in       = s_new[SUM_W-1];
               seed_mode_in = 1'b1;
               den_in       = p_cur;
               rem_in       = CFG_W'(num[NUM_W-1:QUO_W]);
               quo_in       = num[QUO_W-1:0];
               div_cnt_in   = DIV_CNT_W'(QUO_W - 1);
               state_in     = S_DIV;
            end else if (p_cur == CFG_W'(1)) begin
               // smoothing factor of one: take the sample
               avg_in[k_ff] = xs;
               res_in[k_ff] = xs;
               state_in     = S_NEXT;
            end else if (alpha_hit) begin
               state_in = S_DIFF;
            end else begin
               seed_mode_in = 1'b0;
               den_in       = p_cur + CFG_W'(1);
               rem_in       = '0;
               quo_in       = ALPHA_NUM;
               div_cnt_in   = DIV_CNT_W'(QUO_W - 1);
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = qbit ? CFG_W'(trial - {1'b0, den_ff}) : trial[CFG_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], qbit};
            if (div_cnt_ff == '0) begin
               state_in = S_DIV_END;
            end else begin
               div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            end
         end
         S_DIV_END: begin
            if (seed_mode_ff) begin
               avg_in[k_ff] = seed_val;
               res_in[k_ff] = seed_val;
               state_in     = S_NEXT;
            end else begin
               alpha_in[k_ff]    = quo_ff[ALPHA_W-1:0];
               tag_in[k_ff]      = p_cur;
               alpha_ok_in[k_ff] = 1'b1;
               state_in          = S_DIFF;
            end
         end
         S_DIFF: begin
            neg_in   = d[DIFF_W-1];
            mag_in   = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = mul_p;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            lp_in    = prod_ff;
            prod_in  = mul_p;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // floor of the scaled step: round the magnitude up when negative and inexact
            q_in = prod_ff[DIFF_W-1:0] + DIFF_W'(lp_ff[PROD_W-1:ALPHA_W])
                   + DIFF_W'(neg_ff && (lp_ff[ALPHA_W-1:0] != '0));
            state_in = S_APPLY;
         end
         S_APPLY: begin
            avg_in[k_ff] = AVG_W'({avg_ff[k_ff][AVG_W-1], avg_ff[k_ff]} + delta);
            res_in[k_ff] = AVG_W'({avg_ff[k_ff][AVG_W-1], avg_ff[k_ff]} + delta);
            state_in     = S_NEXT;
         end
         S_NEXT: begin
            unique case (k_ff)
               AVG_FAST: begin
                  k_in     = AVG_SLOW;
                  state_in = S_SELECT;
               end
               AVG_SLOW: begin
                  macd_in  = macd_c;
                  k_in     = AVG_SIGNAL;
                  state_in = S_SELECT;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_macd_in   = macd_ff;
               rsp_signal_in = sig_c;
               rsp_hist_in   = sat32({macd_ff[PRICE_W-1], macd_ff} - {sig_c[PRICE_W-1], sig_c});
               if (cnt_ff < MAX_PERIOD) begin
                  cnt_in = cnt_ff + CFG_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         k_ff                 <= AVG_FAST;
         cnt_ff               <= '0;
         len_ff[AVG_FAST]     <= FAST_LENGTH_RESET;
         len_ff[AVG_SLOW]     <= SLOW_LENGTH_RESET;
         len_ff[AVG_SIGNAL]   <= SIGNAL_LENGTH_RESET;
         avg_ff               <= '{default: '0};
         sum_ff               <= '{default: '0};
         alpha_ok_ff          <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         k_ff                 <= k_in;
         cnt_ff               <= cnt_in;
         len_ff               <= len_in;
         avg_ff               <= avg_in;
         sum_ff               <= sum_in;
         alpha_ok_ff          <= alpha_ok_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff      <= price_in;
      macd_ff       <= macd_in;
      res_ff        <= res_in;
      alpha_ff      <= alpha_in;
      tag_ff        <= tag_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      seed_mode_ff  <= seed_mode_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      lp_ff         <= lp_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      rsp_macd_ff   <= rsp_macd_in;
      rsp_signal_ff <= rsp_signal_in;
      rsp_hist_ff   <= rsp_hist_in;
   end

endmodule

### sim/macd_indicator_stream_tb.sv
// Self-checking testbench for the MACD indicator stream: directed table, then randomised phases.
module macd_indicator_stream_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import macd_pkg::*;

   localparam int     RESET_CYCLES = 12;
   localparam int     MAX_GAP      = 4;
   localparam int     STALL_LIMIT  = 2000;   // worst item: one division per average
   localparam int     TAIL_CYCLES  = 40;
   localparam int     MAX_REPORTS  = 10;
   // Random items after the directed table
   localparam int     RANDOM_ITEMS = 535;

   localparam logic signed [PRICE_W-1:0] Q_HI = 32'sh7FFF_FFFF;
   localparam logic signed [PRICE_W-1:0] Q_LO = 32'sh8000_0000;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   localparam csr_index_type REG_UNUSED = CSR_IDX_W'(3);

   typedef struct {
      logic signed [PRICE_W-1:0] macd;
      logic signed [PRICE_W-1:0] signal;
      logic signed [PRICE_W-1:0] hist;
   } macd_result_type;

   typedef enum logic {ROW_PRICE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      csr_index_type             index;
      logic [CFG_W-1:0]          data;
      logic signed [PRICE_W-1:0] price;
      bit                        typed;
      logic signed [PRICE_W-1:0] macd;
      logic signed [PRICE_W-1:0] signal;
      logic signed [PRICE_W-1:0] hist;
   } stim_row_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [PRICE_W-1:0] req_price = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [PRICE_W-1:0] rsp_macd_value;
   logic signed [PRICE_W-1:0] rsp_signal_value;
   logic signed [PRICE_W-1:0] rsp_histogram_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = '0;
   logic [CFG_W-1:0]          csr_data  = '0;

   // Predictor state, indexed by average
   logic [CFG_W-1:0] len_reg [NUM_AVG] = '{FAST_LENGTH_RESET, SLOW_LENGTH_RESET,
                                           SIGNAL_LENGTH_RESET};
   longint           avg_state [NUM_AVG] = '{0, 0, 0};
   longint           seed_sum  [NUM_AVG] = '{0, 0, 0};
   int unsigned      sample_idx = 0;

   macd_result_type  expected_q [$];
   int               failures = 0;
   bit               quiet_stretch = 1'b0;
   longint           walk_level = 0;
   int unsigned      walk_step = 16;

   // Expected values are typed only where they follow at a glance
   localparam int NUM_DIRECTED = 25;
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      // lead-in after reset: every average still zero
      '{ROW_PRICE, REG_UNUSED, '0, 32'sh0000_0000, 1'b1, 32'sh0, 32'sh0, 32'sh0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_HI,           1'b1, 32'sh0, 32'sh0, 32'sh0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_LO,           1'b1, 32'sh0, 32'sh0, 32'sh0},
      '{ROW_PRICE, REG_UNUSED, '0, -32'sh1,        1'b1, 32'sh0, 32'sh0, 32'sh0},
      // zero length acts as one, oversize as the maximum, unknown index dropped
      '{ROW_CSR, REG_FAST_LENGTH,   CFG_W'(0),    '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_SLOW_LENGTH,   CFG_W'(2047), '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_SIGNAL_LENGTH, CFG_W'(0),    '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_UNUSED,        CFG_W'(5),    '0, 1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_HI,           1'b1, Q_HI, Q_HI, 32'sh0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_LO,           1'b1, Q_LO, Q_LO, 32'sh0},
      '{ROW_PRICE, REG_UNUSED, '0, 32'sh0000_0000, 1'b1, 32'sh0, 32'sh0, 32'sh0},
      // swap the periods: MACD saturates while fast and signal are in lead-in
      '{ROW_CSR, REG_FAST_LENGTH,   CFG_W'(1024), '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_SLOW_LENGTH,   CFG_W'(1),    '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_SIGNAL_LENGTH, CFG_W'(2047), '0, 1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_LO,           1'b1, Q_HI, 32'sh0, Q_HI},
      '{ROW_PRICE, REG_UNUSED, '0, Q_HI,           1'b1, 32'sh8000_0001, 32'sh0,
        32'sh8000_0001},
      // back to defaults mid-stream: fast seeds from a mixed sum, signal skips its seed
      '{ROW_CSR, REG_FAST_LENGTH,   FAST_LENGTH_RESET,   '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_SLOW_LENGTH,   SLOW_LENGTH_RESET,   '0, 1'b0, '0, '0, '0},
      '{ROW_CSR, REG_SIGNAL_LENGTH, SIGNAL_LENGTH_RESET, '0, 1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, 32'sh0001_0000, 1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, 32'sh0002_8000, 1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, -32'sh1_0000,   1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, 32'sh1234_5678, 1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_HI,           1'b0, '0, '0, '0},
      '{ROW_PRICE, REG_UNUSED, '0, Q_LO,           1'b0, '0, '0, '0}
   };

   macd_indicator_stream dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_price          (req_price),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_macd_value     (rsp_macd_value),
      .rsp_signal_value   (rsp_signal_value),
      .rsp_histogram_value(rsp_histogram_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void flag_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", what);
   endfunction

   function automatic int unsigned active_period(input logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_PERIOD) return MAX_PERIOD;
      return raw;
   endfunction

   function automatic logic signed [PRICE_W-1:0] clip32(input longint v);
      if (v > Q_MAX) return Q_HI;
      if (v < Q_MIN) return Q_LO;
      return v[PRICE_W-1:0];
   endfunction

   // floor(d * a / 2^32), split so that no partial product exceeds 64 bits
   function automatic longint scale_by_alpha(input longint d, input longint unsigned a);
      longint unsigned mag, lo_prod, q;
      mag = (d < 0) ? -d : d;
      lo_prod = (mag & 64'hFFFF_FFFF) * a;
      q = (mag >> 32) * a + (lo_prod >> 32);
      if (d >= 0) return $signed(q);
      if (lo_prod[31:0] != 32'd0) q = q + 64'd1;
      return -$signed(q);
   endfunction

   // One average step at the current index; x in Q16.16, result in Q16.32
   function automatic longint avg_step(input int k, input longint x, input int unsigned p);
      longint unsigned mag, alpha;
      longint          total;
      if (sample_idx + 1 < p) begin
         seed_sum[k] += x;
         return 0;
      end
      if (sample_idx + 1 == p) begin
         total = seed_sum[k] + x;
         seed_sum[k] = total;
         if (total >= 0) begin
            mag = total << 16;
            avg_state[k] = mag / p;
         end else begin
            mag = (-total) << 16;
            avg_state[k] = -$signed((mag + p - 1) / p);
         end
         return avg_state[k];
      end
      alpha = 64'h2_0000_0000 / (64'(p) + 64'd1);
      avg_state[k] += scale_by_alpha((x <<< 16) - avg_state[k], alpha);
      return avg_state[k];
   endfunction

   function automatic macd_result_type predict_macd(input logic signed [PRICE_W-1:0] price);
      longint          fast_q, slow_q, sig_q;
      macd_result_type r;
      fast_q = avg_step(AVG_FAST, price, active_period(len_reg[AVG_FAST]));
      slow_q = avg_step(AVG_SLOW, price, active_period(len_reg[AVG_SLOW]));
      r.macd = clip32((fast_q - slow_q) >>> 16);
      sig_q = avg_step(AVG_SIGNAL, r.macd, active_period(len_reg[AVG_SIGNAL]));
      r.signal = clip32(sig_q >>> 16);
      r.hist = clip32(longint'(r.macd) - longint'(r.signal));
      if (sample_idx < MAX_PERIOD) sample_idx++;
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] draw_length();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0: return CFG_W'(0);
         1: return CFG_W'(1);
         2: return MAX_PERIOD;
         3: return CFG_W'($urandom_range(1025, 2047));
         4: return CFG_W'($urandom_range(41, 1023));
         default: return CFG_W'($urandom_range(2, 40));
      endcase
   endfunction

   // Mostly a random walk around a level, with some full-range noise and extremes
   function automatic logic signed [PRICE_W-1:0] draw_price();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return $urandom;
      if (pick < 16) begin
         case ($urandom_range(0, 3))
            0: return Q_HI;
            1: return Q_LO;
            2: return '0;
            default: return '1;
         endcase
      end
      walk_level += longint'($urandom_range(0, 2 * walk_step)) - longint'(walk_step);
      if (walk_level > Q_MAX) walk_level = Q_MAX;
      else if (walk_level < Q_MIN) walk_level = Q_MIN;
      return walk_level[PRICE_W-1:0];
   endfunction

   task automatic send_price(input logic signed [PRICE_W-1:0] price);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= price;
      do @(posedge clock); while (!req_ready);
      expected_q.insert(expected_q.size(), predict_macd(price));
   endtask

   // Hold off the price stream and let every result drain before the write
   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      int gap;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FAST_LENGTH:   len_reg[AVG_FAST]   = value;
         REG_SLOW_LENGTH:   len_reg[AVG_SLOW]   = value;
         REG_SIGNAL_LENGTH: len_reg[AVG_SIGNAL] = value;
         default: ;
      endcase
   endtask

   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin : rsp_check
      macd_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            flag_failure($sformatf("result with no transaction pending: macd %0d signal %0d",
                                   rsp_macd_value, rsp_signal_value));
         end else begin
            want = expected_q.pop_front();
            if (rsp_macd_value !== want.macd)
               flag_failure($sformatf("macd_value: expected %0d, got %0d",
                                      want.macd, rsp_macd_value));
            if (rsp_signal_value !== want.signal)
               flag_failure($sformatf("signal_value: expected %0d, got %0d",
                                      want.signal, rsp_signal_value));
            if (rsp_histogram_value !== want.hist)
               flag_failure($sformatf("histogram_value: expected %0d, got %0d",
                                      want.hist, rsp_histogram_value));
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int random_sent;
      int burst;
      random_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_CSR) begin
            write_csr(directed_rows[n].index, directed_rows[n].data);
         end else begin
            send_price(directed_rows[n].price);
            if (directed_rows[n].typed) begin
               expected_q[expected_q.size() - 1] = '{directed_rows[n].macd,
                                                      directed_rows[n].signal,
                                                      directed_rows[n].hist};
            end
         end
      end

      // Each phase: fresh periods written while idle, then a burst around a new level
      while (random_sent < RANDOM_ITEMS) begin
         quiet_stretch = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) write_csr(REG_FAST_LENGTH, draw_length());
         if ($urandom_range(0, 4) != 0) write_csr(REG_SLOW_LENGTH, draw_length());
         if ($urandom_range(0, 4) != 0) write_csr(REG_SIGNAL_LENGTH, draw_length());
         if ($urandom_range(0, 5) == 0) write_csr(REG_UNUSED, CFG_W'($urandom));
         walk_level = longint'($signed($urandom)) >>> $urandom_range(0, 14);
         walk_step = 1 << $urandom_range(4, 24);
         burst = $urandom_range(10, 60);
         if (burst > RANDOM_ITEMS - random_sent) burst = RANDOM_ITEMS - random_sent;
         repeat (burst) begin
            send_price(draw_price());
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
src/macd_pkg.sv
src/macd_indicator_stream.sv
sim/macd_indicator_stream_tb.sv
